/* design/scatr_pkg.sv */
// Shared types, codes and decode tables for the smart card ATR parser.
`timescale 1ns / 1ps
package scatr_pkg;

  typedef enum logic [2:0] {
    PH_TS    = 3'd0,
    PH_T0    = 3'd1,
    PH_IFACE = 3'd2,
    PH_HIST  = 3'd3,
    PH_TCK   = 3'd4,
    PH_AFTER = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    KIND_TS      = 4'd0,
    KIND_T0      = 4'd1,
    KIND_TA      = 4'd2,
    KIND_TB      = 4'd3,
    KIND_TC      = 4'd4,
    KIND_TD      = 4'd5,
    KIND_HIST    = 4'd6,
    KIND_TCK     = 4'd7,
    KIND_GARBAGE = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    CKS_NOT_YET = 2'd0,
    CKS_GOOD    = 2'd1,
    CKS_BAD     = 2'd2,
    CKS_MISSING = 2'd3
  } cks_t;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;
  localparam logic [7:0] TA2_RSVD   = 8'h60;
  localparam logic [7:0] TB1_BIT7   = 8'h80;

  localparam int WARN_BAD_TS = 0;
  localparam int WARN_F_RFU  = 1;
  localparam int WARN_D_RFU  = 2;
  localparam int WARN_TB1    = 3;
  localparam int WARN_TA2    = 4;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  pending;
    logic [3:0]  group;
    logic [3:0]  hist_left;
    logic [7:0]  run_xor;
    cks_t        verdict;
    logic [7:0]  extra;
    logic        inverse;
  } parse_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [3:0]        group_number;
    logic [7:0]        byte_echo;
    logic [3:0]        protocol_number;
    logic [11:0]       clock_rate_factor;
    logic signed [6:0] rate_adjust;
    logic [4:0]        warning_flags;
    logic              inverse_convention;
    cks_t              checksum_state;
    logic              truncated;
    logic [7:0]        garbage_count;
  } atr_result_t;

  localparam parse_state_t STATE_RESET = '{
    phase:     PH_TS,
    pending:   4'd0,
    group:     4'd1,
    hist_left: 4'd0,
    run_xor:   8'd0,
    verdict:   CKS_NOT_YET,
    extra:     8'd0,
    inverse:   1'b0
  };

  // Clock rate conversion factor F from the FI nibble of TA1.
  function automatic logic [11:0] f_lookup(input logic [3:0] fi);
    logic [11:0] f;
    unique case (fi)
      4'd1:    f = 12'd372;
      4'd2:    f = 12'd558;
      4'd3:    f = 12'd744;
      4'd4:    f = 12'd1116;
      4'd5:    f = 12'd1488;
      4'd6:    f = 12'd1860;
      4'd9:    f = 12'd512;
      4'd10:   f = 12'd768;
      4'd11:   f = 12'd1024;
      4'd12:   f = 12'd1536;
      4'd13:   f = 12'd2048;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

  function automatic logic f_is_rfu(input logic [3:0] fi);
    return (fi == 4'd7) || (fi == 4'd8) || (fi == 4'd14) || (fi == 4'd15);
  endfunction

  // Baud rate adjustment D; negative is a reciprocal, -1 and 0 RFU.
  function automatic logic signed [6:0] d_lookup(input logic [3:0] di);
    logic signed [6:0] d;
    unique case (di)
      4'd1:    d = 7'sd1;
      4'd2:    d = 7'sd2;
      4'd3:    d = 7'sd4;
      4'd4:    d = 7'sd8;
      4'd5:    d = 7'sd16;
      4'd8:    d = 7'sd0;
      4'd10:   d = -7'sd2;
      4'd11:   d = -7'sd4;
      4'd12:   d = -7'sd8;
      4'd13:   d = -7'sd16;
      4'd14:   d = -7'sd32;
      4'd15:   d = -7'sd64;
      default: d = -7'sd1;
    endcase
    return d;
  endfunction

endpackage

/* design/scatr_step.sv */
// Per-byte ATR decode: next parse state and the result for one byte.
`timescale 1ns / 1ps
module scatr_step #(
  parameter int GROUP_LIMIT = 15
) (
  input  scatr_pkg::parse_state_t cur,
  input  logic [7:0]              atr_byte,
  input  logic                    end_of_atr,
  output scatr_pkg::parse_state_t nxt,
  output scatr_pkg::atr_result_t  res
);
  import scatr_pkg::*;

  localparam logic [3:0] GroupMax = 4'(GROUP_LIMIT);

  parse_state_t      upd;
  kind_t             kind;
  logic [3:0]        grp;
  logic [3:0]        proto;
  logic [11:0]       fval;
  logic signed [6:0] dval;
  logic [4:0]        flags;
  logic              trunc;
  cks_t              cks;

  function automatic phase_t leave_phase(input logic [3:0] pend, input logic [3:0] hist);
    phase_t p;
    if (pend != 4'd0) p = PH_IFACE;
    else if (hist != 4'd0) p = PH_HIST;
    else p = PH_TCK;
    return p;
  endfunction

  always_comb begin
    upd   = cur;
    kind  = KIND_GARBAGE;
    grp   = 4'd0;
    proto = 4'd0;
    fval  = 12'd0;
    dval  = 7'sd0;
    flags = 5'd0;
    unique case (cur.phase)
      PH_TS: begin
        kind = KIND_TS;
        if (atr_byte == TS_INVERSE) upd.inverse = 1'b1;
        else if (atr_byte != TS_DIRECT) flags[WARN_BAD_TS] = 1'b1;
        upd.phase = PH_T0;
      end
      PH_T0: begin
        kind          = KIND_T0;
        upd.run_xor   = cur.run_xor ^ atr_byte;
        upd.pending   = atr_byte[7:4];
        upd.hist_left = atr_byte[3:0];
        upd.group     = 4'd1;
        upd.phase     = leave_phase(atr_byte[7:4], atr_byte[3:0]);
      end
      PH_IFACE: begin
        upd.run_xor = cur.run_xor ^ atr_byte;
        grp         = cur.group;
        priority if (cur.pending[0]) begin
          kind        = KIND_TA;
          upd.pending = cur.pending & 4'b1110;
          if (cur.group == 4'd1) begin
            fval = f_lookup(atr_byte[7:4]);
            dval = d_lookup(atr_byte[3:0]);
            flags[WARN_F_RFU] = f_is_rfu(atr_byte[7:4]);
            flags[WARN_D_RFU] = (dval == 7'sd0) || (dval == -7'sd1);
          end else if (cur.group == 4'd2) begin
            flags[WARN_TA2] = (atr_byte & TA2_RSVD) != 8'd0;
          end
        end else if (cur.pending[1]) begin
          kind        = KIND_TB;
          upd.pending = cur.pending & 4'b1100;
          flags[WARN_TB1] = (cur.group == 4'd1) && ((atr_byte & TB1_BIT7) != 8'd0);
        end else if (cur.pending[2]) begin
          kind        = KIND_TC;
          upd.pending = cur.pending & 4'b1000;
        end else begin
          kind        = KIND_TD;
          proto       = atr_byte[3:0];
          upd.pending = atr_byte[7:4];
          if (cur.group < GroupMax) upd.group = cur.group + 4'd1;
        end
        upd.phase = leave_phase(upd.pending, cur.hist_left);
      end
      PH_HIST: begin
        kind        = KIND_HIST;
        upd.run_xor = cur.run_xor ^ atr_byte;
        if (cur.hist_left != 4'd0) upd.hist_left = cur.hist_left - 4'd1;
        if (upd.hist_left == 4'd0) upd.phase = PH_TCK;
      end
      PH_TCK: begin
        kind        = KIND_TCK;
        upd.verdict = (atr_byte == cur.run_xor) ? CKS_GOOD : CKS_BAD;
        upd.phase   = PH_AFTER;
      end
      default: begin
        // after TCK, and unused phase codes
        kind = KIND_GARBAGE;
        if (cur.extra != 8'hFF) upd.extra = cur.extra + 8'd1;
      end
    endcase

    cks   = upd.verdict;
    trunc = 1'b0;
    if (end_of_atr) begin
      trunc = (upd.phase != PH_TCK) && (upd.phase != PH_AFTER) && (kind != KIND_GARBAGE);
      if (upd.verdict == CKS_NOT_YET) cks = CKS_MISSING;
    end

    res.kind               = kind;
    res.group_number       = grp;
    res.byte_echo          = atr_byte;
    res.protocol_number    = proto;
    res.clock_rate_factor  = fval;
    res.rate_adjust        = dval;
    res.warning_flags      = flags;
    res.inverse_convention = upd.inverse;
    res.checksum_state     = cks;
    res.truncated          = trunc;
    res.garbage_count      = end_of_atr ? upd.extra : 8'd0;

    // re-arm for the next ATR after the final byte
    nxt = end_of_atr ? STATE_RESET : upd;
  end

endmodule

/* design/smartcard_atr_parser.sv */
// Top level of the ISO 7816-3 answer-to-reset parser.
`timescale 1ns / 1ps
// Takes one ATR byte per transfer and returns one result per byte, in order.
// Throughput is one byte per clock while the result side does not stall; a
// byte's result passes from the input register through the decode to the
// result register and waits there while the result side stalls. The parse
// state is updated from the decode whenever a result loads. A byte flagged
// end_of_atr carries the checksum, truncation and garbage verdicts and returns
// the parser to its reset state.
module smartcard_atr_parser #(
  parameter int GROUP_LIMIT = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_atr_byte,
  input  logic              in_end_of_atr,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        out_byte_kind,
  output logic [3:0]        out_group_number,
  output logic [7:0]        out_byte_echo,
  output logic [3:0]        out_protocol_number,
  output logic [11:0]       out_clock_rate_factor,
  output logic signed [6:0] out_rate_adjust,
  output logic [4:0]        out_warning_flags,
  output logic              out_inverse_convention,
  output logic [1:0]        out_checksum_state,
  output logic              out_truncated,
  output logic [7:0]        out_garbage_count
);
  import scatr_pkg::*;

  logic         in_vld_r;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         out_vld_r;
  atr_result_t  res_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  atr_result_t  res_nxt;
  logic         res_load;
  logic         in_load;

  assign res_load = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || res_load;
  assign in_load  = in_valid && in_ready;

  scatr_step #(
    .GROUP_LIMIT(GROUP_LIMIT)
  ) u_step (
    .cur       (state_r),
    .atr_byte  (in_byte_r),
    .end_of_atr(in_last_r),
    .nxt       (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= STATE_RESET;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (res_load) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // hold payloads while stalled
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_byte_r <= in_atr_byte;
      in_last_r <= in_end_of_atr;
    end
    if (res_load) res_r <= res_nxt;
  end

  assign out_valid              = out_vld_r;
  assign out_byte_kind          = res_r.kind;
  assign out_group_number       = res_r.group_number;
  assign out_byte_echo          = res_r.byte_echo;
  assign out_protocol_number    = res_r.protocol_number;
  assign out_clock_rate_factor  = res_r.clock_rate_factor;
  assign out_rate_adjust        = res_r.rate_adjust;
  assign out_warning_flags      = res_r.warning_flags;
  assign out_inverse_convention = res_r.inverse_convention;
  assign out_checksum_state     = res_r.checksum_state;
  assign out_truncated          = res_r.truncated;
  assign out_garbage_count      = res_r.garbage_count;

endmodule

/* design/scatr_chk.sv */
// Port-level checker for the ATR parser, bound to the top level.
`timescale 1ns / 1ps
module scatr_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [3:0]        out_byte_kind,
  input logic [3:0]        out_group_number,
  input logic [11:0]       out_clock_rate_factor,
  input logic signed [6:0] out_rate_adjust,
  input logic [1:0]        out_checksum_state,
  input logic              out_truncated,
  input logic [7:0]        out_garbage_count
);
  import scatr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_trunc_cks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_truncated |-> out_checksum_state == CKS_MISSING)
    else $error("truncated ATR without missing checksum");

  a_ta1_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_kind != KIND_TA |->
      out_clock_rate_factor == 12'd0 && out_rate_adjust == 7'sd0)
    else $error("F/D reported on a byte other than TA");

  a_ts_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_kind == KIND_TS |->
      out_group_number == 4'd0 &&
      (out_checksum_state == CKS_NOT_YET || out_checksum_state == CKS_MISSING))
    else $error("TS carries group or checksum verdict");

  a_garbage: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_garbage_count != 8'd0 |-> out_byte_kind == KIND_GARBAGE)
    else $error("garbage count on a byte that is not garbage");

endmodule

bind smartcard_atr_parser scatr_chk u_scatr_chk (.*);
